// ===== hdl/bsfc_pkg.sv =====
// Package for the byte S-box Feistel block cipher: types, S-box and update tables.
`default_nettype none

package bsfc_pkg;

  // Operation carried by one input word.
  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_ENC  = 2'd1,
    MODE_DEC  = 2'd2
  } mode_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENC_RND,
    ST_ENC_FIN,
    ST_DEC_FIN,
    ST_DEC_RND,
    ST_DRAIN,
    ST_DONE
  } seq_state_t;

  // One byte update: r[d] ^= S[r[a] ^ (keyed ? subkey : r[b])].
  typedef struct packed {
    logic [3:0] d;
    logic [3:0] a;
    logic       keyed;
    logic [3:0] b;
  } op_t;

  // Update issued by the sequencer toward the datapath.
  typedef struct packed {
    logic valid;
    logic key_ok;
    op_t  op;
  } iss_t;

  localparam int ROUND_OPS_N = 32;
  localparam int FINAL_OPS_N = 24;
  localparam int KEYED_PER_ROUND = 30;

  function automatic op_t kop(input int d, input int a);
    op_t o;
    o.d = 4'(d);
    o.a = 4'(a);
    o.keyed = 1'b1;
    o.b = 4'd0;
    return o;
  endfunction

  function automatic op_t uop(input int d, input int a, input int b);
    op_t o;
    o.d = 4'(d);
    o.a = 4'(a);
    o.keyed = 1'b0;
    o.b = 4'(b);
    return o;
  endfunction

  localparam op_t ROUND_OPS [ROUND_OPS_N] = '{
    kop(4, 0), kop(5, 1), kop(6, 2), kop(7, 3),
    kop(12, 8), kop(13, 9), kop(14, 10), kop(15, 11),
    kop(4, 12), kop(5, 13), kop(6, 14), kop(7, 15),
    kop(12, 4), kop(13, 5), kop(14, 6), kop(15, 7),
    kop(1, 4), uop(2, 4, 5), kop(3, 6), kop(0, 7),
    kop(9, 12), uop(10, 12, 13), kop(11, 14), kop(8, 15),
    kop(1, 9), kop(2, 10), kop(3, 11), kop(0, 8),
    kop(9, 1), kop(10, 2), kop(11, 3), kop(8, 0)
  };

  localparam op_t FINAL_OPS [FINAL_OPS_N] = '{
    kop(4, 0), kop(5, 1), kop(6, 2), kop(7, 3),
    kop(12, 8), kop(13, 9), kop(14, 10), kop(15, 11),
    kop(4, 12), kop(5, 13), kop(6, 14), kop(7, 15),
    kop(12, 4), kop(13, 5), kop(14, 6), kop(15, 7),
    kop(1, 9), kop(2, 10), kop(3, 11), kop(0, 8),
    kop(9, 1), kop(10, 2), kop(11, 3), kop(8, 0)
  };

  localparam logic [7:0] SBOX [256] = '{
    8'd32, 8'd137, 8'd239, 8'd188, 8'd102, 8'd125, 8'd221, 8'd72,
    8'd212, 8'd68, 8'd81, 8'd37, 8'd86, 8'd237, 8'd147, 8'd149,
    8'd70, 8'd229, 8'd17, 8'd124, 8'd115, 8'd207, 8'd33, 8'd20,
    8'd122, 8'd143, 8'd25, 8'd215, 8'd51, 8'd183, 8'd138, 8'd142,
    8'd146, 8'd211, 8'd110, 8'd173, 8'd1, 8'd228, 8'd189, 8'd14,
    8'd103, 8'd78, 8'd162, 8'd36, 8'd253, 8'd167, 8'd116, 8'd255,
    8'd158, 8'd45, 8'd185, 8'd50, 8'd98, 8'd168, 8'd250, 8'd235,
    8'd54, 8'd141, 8'd195, 8'd247, 8'd240, 8'd63, 8'd148, 8'd2,
    8'd224, 8'd169, 8'd214, 8'd180, 8'd62, 8'd22, 8'd117, 8'd108,
    8'd19, 8'd172, 8'd161, 8'd159, 8'd160, 8'd47, 8'd43, 8'd171,
    8'd194, 8'd175, 8'd178, 8'd56, 8'd196, 8'd112, 8'd23, 8'd220,
    8'd89, 8'd21, 8'd164, 8'd130, 8'd157, 8'd8, 8'd85, 8'd251,
    8'd216, 8'd44, 8'd94, 8'd179, 8'd226, 8'd38, 8'd90, 8'd119,
    8'd40, 8'd202, 8'd34, 8'd206, 8'd35, 8'd69, 8'd231, 8'd246,
    8'd29, 8'd109, 8'd74, 8'd71, 8'd176, 8'd6, 8'd60, 8'd145,
    8'd65, 8'd13, 8'd77, 8'd151, 8'd12, 8'd127, 8'd95, 8'd199,
    8'd57, 8'd101, 8'd5, 8'd232, 8'd150, 8'd210, 8'd129, 8'd24,
    8'd181, 8'd10, 8'd121, 8'd187, 8'd48, 8'd193, 8'd139, 8'd252,
    8'd219, 8'd64, 8'd88, 8'd233, 8'd96, 8'd128, 8'd80, 8'd53,
    8'd191, 8'd144, 8'd218, 8'd11, 8'd106, 8'd132, 8'd155, 8'd104,
    8'd91, 8'd136, 8'd31, 8'd42, 8'd243, 8'd66, 8'd126, 8'd135,
    8'd30, 8'd26, 8'd87, 8'd186, 8'd182, 8'd154, 8'd242, 8'd123,
    8'd82, 8'd166, 8'd208, 8'd39, 8'd152, 8'd190, 8'd113, 8'd205,
    8'd114, 8'd105, 8'd225, 8'd84, 8'd73, 8'd163, 8'd99, 8'd111,
    8'd204, 8'd61, 8'd200, 8'd217, 8'd170, 8'd15, 8'd198, 8'd28,
    8'd192, 8'd254, 8'd134, 8'd234, 8'd222, 8'd7, 8'd236, 8'd248,
    8'd201, 8'd41, 8'd177, 8'd156, 8'd92, 8'd131, 8'd67, 8'd249,
    8'd245, 8'd184, 8'd203, 8'd9, 8'd241, 8'd0, 8'd27, 8'd46,
    8'd133, 8'd174, 8'd75, 8'd18, 8'd93, 8'd209, 8'd100, 8'd120,
    8'd76, 8'd213, 8'd16, 8'd83, 8'd4, 8'd107, 8'd140, 8'd52,
    8'd58, 8'd55, 8'd3, 8'd244, 8'd97, 8'd197, 8'd238, 8'd227,
    8'd118, 8'd49, 8'd79, 8'd230, 8'd223, 8'd165, 8'd153, 8'd59
  };

endpackage

`default_nettype wire

// ===== hdl/bsfc_if.sv =====
// Valid/ready channel interfaces for the cipher's input and result words.
`default_nettype none

interface bsfc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [10:0] key_index;
  logic [7:0]  key_byte;
  logic [63:0] block_hi;
  logic [63:0] block_lo;

  modport source (output valid, mode, key_index, key_byte, block_hi, block_lo,
                  input ready);
  modport sink (input valid, mode, key_index, key_byte, block_hi, block_lo,
                output ready);
endinterface

interface bsfc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_hi;
  logic [63:0] out_lo;

  modport source (output valid, out_hi, out_lo, input ready);
  modport sink (input valid, out_hi, out_lo, output ready);
endinterface

`default_nettype wire

// ===== hdl/bsfc_key_ram.sv =====
// Single-port subkey memory with registered read data.
`default_nettype none

module bsfc_key_ram #(
  parameter int DEPTH = 1944,
  parameter int AW = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [7:0]    wdata,
  output logic      [7:0]    rdata_r
);

  logic [7:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

endmodule

`default_nettype wire

// ===== hdl/bsfc_seq.sv =====
// Update sequencer: walks the round and final update lists and the subkey index.
`default_nettype none

module bsfc_seq #(
  parameter int ROUND_COUNT = 64,
  parameter int SUBKEY_DEPTH = 1944,
  parameter int KI_W = 11
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start_enc,
  input  wire logic            start_dec,
  input  wire logic            out_free,
  output logic                 idle,
  output logic                 xfer,
  output bsfc_pkg::iss_t       iss,
  output logic      [KI_W-1:0] key_addr
);

  localparam int RW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam int KEY_LAST = bsfc_pkg::KEYED_PER_ROUND * ROUND_COUNT
                            + bsfc_pkg::FINAL_OPS_N - 1;
  localparam logic [RW-1:0] RND_LAST = RW'(ROUND_COUNT - 1);
  localparam logic [4:0] RND_OP_LAST = 5'(bsfc_pkg::ROUND_OPS_N - 1);
  localparam logic [4:0] FIN_OP_LAST = 5'(bsfc_pkg::FINAL_OPS_N - 1);

  bsfc_pkg::seq_state_t state_r, state_nxt;
  logic [4:0]      op_r, op_nxt;
  logic [RW-1:0]   rnd_r, rnd_nxt;
  logic [KI_W-1:0] ki_r, ki_nxt;
  bsfc_pkg::op_t   cur_op;
  logic            issuing;

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    rnd_nxt = rnd_r;
    ki_nxt = ki_r;
    if (issuing && cur_op.keyed) begin
      if (state_r == bsfc_pkg::ST_ENC_RND || state_r == bsfc_pkg::ST_ENC_FIN) begin
        ki_nxt = ki_r + 1'b1;
      end else begin
        ki_nxt = ki_r - 1'b1;
      end
    end
    unique case (state_r)
      bsfc_pkg::ST_IDLE: begin
        if (start_enc) begin
          state_nxt = bsfc_pkg::ST_ENC_RND;
          op_nxt = 5'd0;
          rnd_nxt = '0;
          ki_nxt = '0;
        end else if (start_dec) begin
          state_nxt = bsfc_pkg::ST_DEC_FIN;
          op_nxt = FIN_OP_LAST;
          rnd_nxt = '0;
          ki_nxt = KI_W'(KEY_LAST);
        end
      end
      bsfc_pkg::ST_ENC_RND: begin
        if (op_r == RND_OP_LAST) begin
          op_nxt = 5'd0;
          if (rnd_r == RND_LAST) begin
            state_nxt = bsfc_pkg::ST_ENC_FIN;
          end else begin
            rnd_nxt = rnd_r + 1'b1;
          end
        end else begin
          op_nxt = op_r + 5'd1;
        end
      end
      bsfc_pkg::ST_ENC_FIN: begin
        if (op_r == FIN_OP_LAST) begin
          state_nxt = bsfc_pkg::ST_DRAIN;
        end else begin
          op_nxt = op_r + 5'd1;
        end
      end
      bsfc_pkg::ST_DEC_FIN: begin
        if (op_r == 5'd0) begin
          state_nxt = bsfc_pkg::ST_DEC_RND;
          op_nxt = RND_OP_LAST;
        end else begin
          op_nxt = op_r - 5'd1;
        end
      end
      bsfc_pkg::ST_DEC_RND: begin
        if (op_r == 5'd0) begin
          if (rnd_r == RND_LAST) begin
            state_nxt = bsfc_pkg::ST_DRAIN;
          end else begin
            rnd_nxt = rnd_r + 1'b1;
            op_nxt = RND_OP_LAST;
          end
        end else begin
          op_nxt = op_r - 5'd1;
        end
      end
      bsfc_pkg::ST_DRAIN: begin
        state_nxt = bsfc_pkg::ST_DONE;
      end
      bsfc_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = bsfc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bsfc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    issuing = (state_r == bsfc_pkg::ST_ENC_RND) || (state_r == bsfc_pkg::ST_ENC_FIN) ||
              (state_r == bsfc_pkg::ST_DEC_FIN) || (state_r == bsfc_pkg::ST_DEC_RND);
    if (state_r == bsfc_pkg::ST_ENC_RND || state_r == bsfc_pkg::ST_DEC_RND) begin
      cur_op = bsfc_pkg::ROUND_OPS[op_r];
    end else begin
      cur_op = bsfc_pkg::FINAL_OPS[op_r];
    end
    iss.valid = issuing;
    iss.op = cur_op;
    iss.key_ok = (32'(ki_r) < SUBKEY_DEPTH);
    idle = (state_r == bsfc_pkg::ST_IDLE);
    xfer = (state_r == bsfc_pkg::ST_DONE) && out_free;
    key_addr = ki_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsfc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    op_r <= op_nxt;
    rnd_r <= rnd_nxt;
    ki_r <= ki_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/bsfc_core.sv =====
// Sixteen byte registers and the shared S-box XOR update unit.
`default_nettype none

module bsfc_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           load,
  input  wire logic [63:0]    load_hi,
  input  wire logic [63:0]    load_lo,
  input  wire bsfc_pkg::iss_t iss,
  input  wire logic [7:0]     key_byte,
  output logic                busy,
  output logic      [63:0]    state_hi,
  output logic      [63:0]    state_lo
);

  bsfc_pkg::iss_t iss_r;
  logic [7:0] r_r [16];
  logic [7:0] r_nxt [16];
  logic [7:0] opnd;
  logic [7:0] x;

  // The issued update is registered so it lines up with the subkey read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r.valid <= 1'b0;
    end else begin
      iss_r.valid <= iss.valid;
    end
    iss_r.key_ok <= iss.key_ok;
    iss_r.op <= iss.op;
  end

  always_comb begin
    if (iss_r.op.keyed) begin
      opnd = iss_r.key_ok ? key_byte : 8'h00;
    end else begin
      opnd = r_r[iss_r.op.b];
    end
    x = r_r[iss_r.op.a] ^ opnd;
    for (int j = 0; j < 16; j++) begin
      r_nxt[j] = r_r[j];
    end
    if (load) begin
      for (int j = 0; j < 8; j++) begin
        r_nxt[j] = load_hi[63 - 8 * j -: 8];
        r_nxt[8 + j] = load_lo[63 - 8 * j -: 8];
      end
    end else if (iss_r.valid) begin
      r_nxt[iss_r.op.d] = r_r[iss_r.op.d] ^ bsfc_pkg::SBOX[x];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 16; j++) begin
      r_r[j] <= r_nxt[j];
    end
  end

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      state_hi[63 - 8 * j -: 8] = r_r[j];
      state_lo[63 - 8 * j -: 8] = r_r[8 + j];
    end
    busy = iss_r.valid;
  end

endmodule

`default_nettype wire

// ===== hdl/byte_sbox_feistel_block_cipher.sv =====
// Top level of the 128-bit byte S-box Feistel block cipher.
// Sequence: an encrypt or decrypt word runs the round and final updates, then a drain
//   step, before the result moves to the output register; a load word writes the subkey memory in the accept cycle.
// Throughput: one update per cycle through the shared S-box unit fed by the single-port
//   subkey memory; a new block word is taken only once the last has left the sequencer,
//   and later while the output register still holds an untaken result.
//   Loads are taken every cycle while the sequencer is idle.
// Reset: synchronous, active low; clears the sequencer and valid flags only.
//   The subkey memory is not cleared and must be loaded before use.
`default_nettype none

module byte_sbox_feistel_block_cipher #(
  parameter int ROUND_COUNT = 64,
  parameter int SUBKEY_DEPTH = 1944
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bsfc_in_if.sink    in_ch,
  bsfc_out_if.source out_ch
);

  // Subkeys actually consumed by one block, and the index width that walks them.
  localparam int KEY_USE = bsfc_pkg::KEYED_PER_ROUND * ROUND_COUNT + bsfc_pkg::FINAL_OPS_N;
  localparam int KI_W = $clog2(KEY_USE);
  localparam int AW = $clog2(SUBKEY_DEPTH);

  logic            in_acc;
  logic            start_enc;
  logic            start_dec;
  logic            key_we;
  logic            seq_idle;
  logic            xfer;
  logic            out_free;
  logic            core_busy;
  bsfc_pkg::iss_t  iss;
  logic [KI_W-1:0] key_addr;
  logic [31:0]     key_addr_ext;
  logic [AW-1:0]   ram_addr;
  logic [7:0]      ram_rdata;
  logic [63:0]     state_hi;
  logic [63:0]     state_lo;

  logic            out_valid_r, out_valid_nxt;
  logic [63:0]     out_hi_r;
  logic [63:0]     out_lo_r;

  // A word is taken only while the sequencer is idle. A load writes the
  // subkey memory in the accept cycle; an out-of-range index is dropped.
  // Mode three is accepted and discarded.
  assign in_ch.ready = seq_idle;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign start_enc = in_acc && (in_ch.mode == bsfc_pkg::MODE_ENC);
  assign start_dec = in_acc && (in_ch.mode == bsfc_pkg::MODE_DEC);
  assign key_we = in_acc && (in_ch.mode == bsfc_pkg::MODE_LOAD) &&
                  (32'(in_ch.key_index) < SUBKEY_DEPTH);

  // The single memory port serves the load write while idle and the subkey
  // read stream while a block is in flight.
  assign key_addr_ext = 32'(key_addr);
  assign ram_addr = seq_idle ? in_ch.key_index[AW-1:0] : key_addr_ext[AW-1:0];

  // The finished block moves to the output register once it is free, so the
  // next word can be taken while the result waits for the sink.
  assign out_free = !out_valid_r || out_ch.ready;

  bsfc_key_ram #(
    .DEPTH(SUBKEY_DEPTH),
    .AW   (AW)
  ) u_key_ram (
    .clk    (clk),
    .we     (key_we),
    .addr   (ram_addr),
    .wdata  (in_ch.key_byte),
    .rdata_r(ram_rdata)
  );

  bsfc_seq #(
    .ROUND_COUNT (ROUND_COUNT),
    .SUBKEY_DEPTH(SUBKEY_DEPTH),
    .KI_W        (KI_W)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_enc(start_enc),
    .start_dec(start_dec),
    .out_free (out_free),
    .idle     (seq_idle),
    .xfer     (xfer),
    .iss      (iss),
    .key_addr (key_addr)
  );

  bsfc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (start_enc || start_dec),
    .load_hi (in_ch.block_hi),
    .load_lo (in_ch.block_lo),
    .iss     (iss),
    .key_byte(ram_rdata),
    .busy    (core_busy),
    .state_hi(state_hi),
    .state_lo(state_lo)
  );

  always_comb begin
    if (xfer) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (xfer) begin
      out_hi_r <= state_hi;
      out_lo_r <= state_lo;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.out_hi = out_hi_r;
  assign out_ch.out_lo = out_lo_r;

  // No update may still be in the datapath when a new word is taken.
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !core_busy)
    else $error("word accepted while an update is in flight");

  // A block word starts the sequencer, which leaves idle at once.
  a_block_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start_enc || start_dec) |=> !in_ch.ready)
    else $error("sequencer did not start on a block word");

  // A load word never stalls the input.
  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.mode == bsfc_pkg::MODE_LOAD)) |=> in_ch.ready)
    else $error("load word left the sequencer busy");

  // The result is copied only after the last update has landed.
  a_xfer_drained: assert property (@(posedge clk) disable iff (!rst_n)
    xfer |-> (!core_busy && !iss.valid))
    else $error("result copied while updates are pending");

endmodule

`default_nettype wire
